@@ rtl/core/stmh_pkg.sv @@
// stmh_pkg: shared types and constants for the sleep timer min-heap
// no dependencies; used by the interfaces, the heap memory and the top level
package stmh_pkg;

  localparam int unsigned WAKE_W      = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned TPS_W       = 10;
  localparam int unsigned PROD_W      = DUR_W - 1 + TPS_W;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned POP_W       = 6;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10);

  localparam logic OP_SLEEP   = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [WAKE_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

@@ rtl/core/stmh_if.sv @@
// stmh_if: valid/ready channels for sleep/tick items, results and configuration
// depends on stmh_pkg for field widths
interface stmh_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [stmh_pkg::DUR_W-1:0] duration;
  logic        [stmh_pkg::ID_W-1:0]  requester_id;

  modport source (output valid, output opcode, output duration, output requester_id,
                  input ready);
  modport sink   (input valid, input opcode, input duration, input requester_id,
                  output ready);
endinterface

interface stmh_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [stmh_pkg::STATUS_W-1:0]    status;
  logic [stmh_pkg::ID_W-1:0]        woken_id;
  logic                             last;

  modport source (output valid, output kind, output status, output woken_id, output last,
                  input ready);
  modport sink   (input valid, input kind, input status, input woken_id, input last,
                  output ready);
endinterface

interface stmh_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [stmh_pkg::TPS_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/stmh_heap_mem.sv @@
// stmh_heap_mem: heap entry storage, one write and one registered read per cycle
// depends on stmh_pkg for the entry type
module stmh_heap_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  stmh_pkg::entry_t                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output stmh_pkg::entry_t                           rdata
);

  stmh_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // same-address write is seen by the read
    rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

endmodule

@@ rtl/core/sleep_timer_min_heap_top.sv @@
// sleep_timer_min_heap_top: sleep timer queue kept as a binary min-heap by wake tick
// one memory read port walks the heap under a small sequencer; depends on stmh_pkg,
// the stmh channel interfaces and stmh_heap_mem
// sleep: a rejected item goes straight to the response; an accepted one gets its wake tick, then sifts up
// tick: the root is checked and each due entry is popped, then sifted down level by level; one item at a time
// the single heap read port sets the pace; ready only in idle
// reset: heap empty, tick count zero, ticks_per_second 10; heap contents undefined
module sleep_timer_min_heap_top #(
  parameter int unsigned HEAP_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  stmh_in_if.sink   in_bus,
  stmh_out_if.source out_bus,
  stmh_cfg_if.sink  cfg_bus
);

  localparam int unsigned AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAKE,
    S_UP,
    S_UPCMP,
    S_RESP,
    S_ROOT,
    S_POPLAST,
    S_DN,
    S_DNL,
    S_DNR,
    S_DNDEC
  } state_t;

  state_t                          state_r, state_nxt;
  logic [stmh_pkg::TPS_W-1:0]      tps_r, tps_nxt;
  logic [stmh_pkg::WAKE_W-1:0]     tick_r, tick_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic [AW-1:0]                   best_r, best_nxt;
  stmh_pkg::entry_t                x_r, x_nxt;
  stmh_pkg::entry_t                bestv_r, bestv_nxt;
  logic [stmh_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic                            pend_r, pend_nxt;
  logic [stmh_pkg::ID_W-1:0]       pend_id_r, pend_id_nxt;
  logic [stmh_pkg::POP_W-1:0]      pops_r, pops_nxt;
  stmh_pkg::status_t               status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_kind_r, out_kind_nxt;
  stmh_pkg::status_t               out_status_r, out_status_nxt;
  logic [stmh_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  stmh_pkg::entry_t                mem_wdata;
  logic [AW-1:0]                   mem_raddr;
  stmh_pkg::entry_t                mem_rdata;

  logic                            in_beat;
  logic                            emit_ok;
  logic                            due;
  logic [AW-1:0]                   parent;
  logic [CHW-1:0]                  child_l;
  logic [CHW-1:0]                  child_r;
  logic [CHW-1:0]                  count_ext;
  logic [stmh_pkg::WAKE_W:0]       wake_sum;

  stmh_heap_mem #(
    .DEPTH (HEAP_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_bus.ready     = (state_r == S_IDLE);
  assign cfg_bus.ready    = 1'b1;
  assign out_bus.valid    = out_valid_r;
  assign out_bus.kind     = out_kind_r;
  assign out_bus.status   = out_status_r;
  assign out_bus.woken_id = out_id_r;
  assign out_bus.last     = out_last_r;

  assign in_beat   = in_bus.valid && (state_r == S_IDLE);
  assign emit_ok   = !out_valid_r || out_bus.ready;
  assign parent    = AW'((pos_r - 1'b1) >> 1);
  assign child_l   = {1'b0, pos_r, 1'b1};
  assign child_r   = child_l + 1'b1;
  assign count_ext = CHW'(count_r);
  assign wake_sum  = {1'b0, tick_r} + (stmh_pkg::WAKE_W + 1)'(prod_r);
  assign due       = (count_r != '0) && (mem_rdata.wake <= tick_r)
                     && (pops_r < stmh_pkg::POP_W'(stmh_pkg::MAX_RESULTS));

  always_comb begin
    state_nxt      = state_r;
    tps_nxt        = tps_r;
    tick_nxt       = tick_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    best_nxt       = best_r;
    x_nxt          = x_r;
    bestv_nxt      = bestv_r;
    prod_nxt       = prod_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    pops_nxt       = pops_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = x_r;
    mem_raddr      = '0;

    if (cfg_bus.valid) begin
      tps_nxt = cfg_bus.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_bus.opcode == stmh_pkg::OP_TICK) begin
            if (tick_r != '1) begin
              tick_nxt = tick_r + 1'b1;
            end
            pops_nxt  = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_ROOT;
          end else if (in_bus.duration[stmh_pkg::DUR_W-1]) begin
            status_nxt = stmh_pkg::ST_NEG;
            state_nxt  = S_RESP;
          end else if (count_r == CW'(HEAP_DEPTH)) begin
            status_nxt = stmh_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            prod_nxt  = in_bus.duration[stmh_pkg::DUR_W-2:0] * tps_r;
            x_nxt.id  = in_bus.requester_id;
            state_nxt = S_WAKE;
          end
        end
      end
      S_WAKE: begin
        x_nxt.wake = wake_sum[stmh_pkg::WAKE_W] ? '1 : wake_sum[stmh_pkg::WAKE_W-1:0];
        pos_nxt    = count_r[AW-1:0];
        state_nxt  = S_UP;
      end
      S_UP: begin
        if (pos_r == '0) begin
          mem_we     = 1'b1;
          count_nxt  = count_r + 1'b1;
          status_nxt = stmh_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          mem_raddr = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        mem_we = 1'b1;
        if (mem_rdata.wake > x_r.wake) begin
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          count_nxt  = count_r + 1'b1;
          status_nxt = stmh_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = stmh_pkg::KIND_SLEEP;
          out_status_nxt = status_r;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ROOT: begin
        if (due) begin
          if (!pend_r || emit_ok) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = stmh_pkg::KIND_WAKE;
              out_status_nxt = stmh_pkg::ST_OK;
              out_id_nxt     = pend_id_r;
              out_last_nxt   = 1'b0;
            end
            pend_nxt    = 1'b1;
            pend_id_nxt = mem_rdata.id;
            pops_nxt    = pops_r + 1'b1;
            count_nxt   = count_r - 1'b1;
            mem_raddr   = AW'(count_r - 1'b1);
            state_nxt   = S_POPLAST;
          end
        end else if (pend_r) begin
          if (emit_ok) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = stmh_pkg::KIND_WAKE;
            out_status_nxt = stmh_pkg::ST_OK;
            out_id_nxt     = pend_id_r;
            out_last_nxt   = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POPLAST: begin
        if (count_r == '0) begin
          state_nxt = S_ROOT;
        end else begin
          x_nxt     = mem_rdata;
          pos_nxt   = '0;
          state_nxt = S_DN;
        end
      end
      S_DN: begin
        if (child_l >= count_ext) begin
          mem_we    = 1'b1;
          state_nxt = S_ROOT;
        end else begin
          mem_raddr = child_l[AW-1:0];
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        if (mem_rdata.wake < x_r.wake) begin
          best_nxt  = child_l[AW-1:0];
          bestv_nxt = mem_rdata;
        end else begin
          best_nxt  = pos_r;
          bestv_nxt = x_r;
        end
        if (child_r < count_ext) begin
          mem_raddr = child_r[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNDEC;
        end
      end
      S_DNR: begin
        if (mem_rdata.wake < bestv_r.wake) begin
          best_nxt  = child_r[AW-1:0];
          bestv_nxt = mem_rdata;
        end
        state_nxt = S_DNDEC;
      end
      S_DNDEC: begin
        mem_we = 1'b1;
        if (best_r == pos_r) begin
          state_nxt = S_ROOT;
        end else begin
          mem_wdata = bestv_r;
          pos_nxt   = best_r;
          state_nxt = S_DN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tps_r       <= stmh_pkg::TPS_RESET;
      tick_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      pops_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tps_r       <= tps_nxt;
      tick_r      <= tick_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      pops_r      <= pops_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    best_r       <= best_nxt;
    x_r          <= x_nxt;
    bestv_r      <= bestv_nxt;
    prod_r       <= prod_nxt;
    pend_id_r    <= pend_id_nxt;
    status_r     <= status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
